// ===== src/serial_frame_receiver_checksum_core_defines.svh =====
// Assertion macros shared by the serial frame receiver RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/sfrc_pkg.sv =====
// Shared types and constants of the serial frame receiver.
// No dependencies; the interfaces, the controller, the datapath and the top level import this package.
`timescale 1ns / 1ps

package sfrc_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_LEN_W  = 6;
  localparam int OUT_IDX_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'd175;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 1'b0,
    REG_HEADER_SECOND = 1'b1
  } cfg_reg_e;

  typedef enum logic [7:0] {
    S_HDR1 = 8'b0000_0001,
    S_HDR2 = 8'b0000_0010,
    S_CODE = 8'b0000_0100,
    S_LEN  = 8'b0000_1000,
    S_DATA = 8'b0001_0000,
    S_SUM  = 8'b0010_0000,
    S_READ = 8'b0100_0000,
    S_LOAD = 8'b1000_0000
  } ctrl_state_e;

  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic code_load;
    logic len_load;
    logic store_wr;
    logic emit_start;
    logic ram_rd;
    logic out_load_data;
    logic out_load_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_too_big;
    logic len_zero;
    logic fill_done;
    logic sum_match;
    logic frame_empty;
    logic emit_last;
    logic out_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/sfrc_in_if.sv =====
// Input channel of the serial frame receiver: one received byte or a timeout per beat.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

interface sfrc_in_if;
  import sfrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

// ===== src/sfrc_out_if.sv =====
// Result channel of the serial frame receiver: one payload byte of a good frame per beat.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

interface sfrc_out_if;
  import sfrc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    func_code;
  logic [OUT_LEN_W-1:0] payload_length;
  logic [BYTE_W-1:0]    payload_byte;
  logic [OUT_IDX_W-1:0] byte_index;
  logic                 last;

  modport source (output valid, output func_code, output payload_length, output payload_byte,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input func_code, input payload_length, input payload_byte,
                  input byte_index, input last, output ready);
endinterface

// ===== src/sfrc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/sfrc_ctrl.sv =====
// Controller of the serial frame receiver: receive phases and the result run sequencer.
// Depends on sfrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_frame_receiver_checksum_core_defines.svh"

module sfrc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 timed_out_i,
  output logic                 in_ready_o,
  input  sfrc_pkg::dp_status_t status_i,
  output sfrc_pkg::dp_cmd_t    cmd_o
);
  import sfrc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        rx_phase;
  logic        in_accept;

  // Only receive phases take bytes; the checksum beat also needs a free output slot.
  assign rx_phase   = (state_q != S_READ) && (state_q != S_LOAD);
  assign in_ready_o = rx_phase && !((state_q == S_SUM) && status_i.out_busy);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_HDR1: begin
        if (in_accept && !timed_out_i) begin
          cmd_o.sum_load = 1'b1;
          state_d = status_i.hdr1_match ? S_HDR2 : S_HDR1;
        end
      end
      S_HDR2: begin
        if (in_accept && !timed_out_i) begin
          cmd_o.sum_add = 1'b1;
          state_d = status_i.hdr2_match ? S_CODE : S_HDR1;
        end
      end
      S_CODE: begin
        if (in_accept && !timed_out_i) begin
          cmd_o.sum_add   = 1'b1;
          cmd_o.code_load = 1'b1;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (in_accept && !timed_out_i) begin
          cmd_o.sum_add  = 1'b1;
          cmd_o.len_load = 1'b1;
          priority if (status_i.len_too_big) begin
            state_d = S_HDR1;
          end else if (status_i.len_zero) begin
            state_d = S_SUM;
          end else begin
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (in_accept && !timed_out_i) begin
          cmd_o.sum_add  = 1'b1;
          cmd_o.store_wr = 1'b1;
          state_d = status_i.fill_done ? S_SUM : S_DATA;
        end
      end
      S_SUM: begin
        if (in_accept && !timed_out_i) begin
          state_d = S_HDR1;
          if (status_i.sum_match) begin
            if (status_i.frame_empty) begin
              cmd_o.out_load_empty = 1'b1;
            end else begin
              cmd_o.emit_start = 1'b1;
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load_data = 1'b1;
          state_d = status_i.emit_last ? S_HDR1 : S_READ;
        end
      end
      default: begin
        state_d = S_HDR1;
      end
    endcase
    // A timeout drops whatever frame is in progress.
    if (in_accept && timed_out_i) begin
      state_d = S_HDR1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HDR1;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_timeout_to_hunt, clk_i, rst_ni, in_accept && timed_out_i, state_q == S_HDR1)
  `ASSERT_NEXT(a_sum_leaves, clk_i, rst_ni, in_accept && (state_q == S_SUM), state_q != S_SUM)
endmodule

// ===== src/sfrc_dp.sv =====
// Datapath of the serial frame receiver: header registers, checksum, payload store, result register.
// Depends on sfrc_pkg, sfrc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_frame_receiver_checksum_core_defines.svh"

module sfrc_dp #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfrc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [sfrc_pkg::BYTE_W-1:0]         rx_byte_i,
  input  sfrc_pkg::dp_cmd_t                   cmd_i,
  output sfrc_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sfrc_pkg::BYTE_W-1:0]         func_code_o,
  output logic [sfrc_pkg::OUT_LEN_W-1:0]      payload_length_o,
  output logic [sfrc_pkg::BYTE_W-1:0]         payload_byte_o,
  output logic [sfrc_pkg::OUT_IDX_W-1:0]      byte_index_o,
  output logic                                last_o
);
  import sfrc_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0]    hdr_first_q, hdr_second_q;
  logic [BYTE_W-1:0]    sum_q, sum_d;
  logic [BYTE_W-1:0]    code_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     fill_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [LEN_W:0]       fill_next;
  logic [LEN_W:0]       rd_next;
  logic [BYTE_W-1:0]    ram_rdata;
  logic [7:0]           len_wide, idx_wide;
  logic                 len_too_big;

  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_code_q, out_byte_q;
  logic [OUT_LEN_W-1:0] out_len_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic                 out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HDR_FIRST_RST;
      hdr_second_q <= HDR_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER_FIRST:  hdr_first_q  <= cfg_wdata_i;
        REG_HEADER_SECOND: hdr_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign len_too_big = rx_byte_i > BYTE_W'(MAX_PAYLOAD);
  assign fill_next   = (LEN_W + 1)'(fill_q) + (LEN_W + 1)'(1);
  assign rd_next     = (LEN_W + 1)'(rd_idx_q) + (LEN_W + 1)'(1);

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.sum_load) begin
      sum_d = rx_byte_i;
    end else if (cmd_i.sum_add) begin
      sum_d = sum_q + rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      code_q   <= '0;
      len_q    <= '0;
      fill_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (cmd_i.code_load) begin
        code_q <= rx_byte_i;
      end
      if (cmd_i.len_load) begin
        fill_q <= '0;
        if (!len_too_big) begin
          len_q <= LEN_W'(rx_byte_i);
        end
      end else if (cmd_i.store_wr) begin
        fill_q <= fill_next[LEN_W-1:0];
      end
      if (cmd_i.emit_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.out_load_data) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  sfrc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_wr),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Output fields keep only their own low bits of the length and the index.
  assign len_wide = 8'(len_q);
  assign idx_wide = 8'(rd_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_data || cmd_i.out_load_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_data) begin
      out_code_q <= code_q;
      out_len_q  <= len_wide[OUT_LEN_W-1:0];
      out_byte_q <= ram_rdata;
      out_idx_q  <= idx_wide[OUT_IDX_W-1:0];
      out_last_q <= (rd_next == (LEN_W + 1)'(len_q));
    end else if (cmd_i.out_load_empty) begin
      out_code_q <= code_q;
      out_len_q  <= '0;
      out_byte_q <= '0;
      out_idx_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign status_o.hdr1_match  = rx_byte_i == hdr_first_q;
  assign status_o.hdr2_match  = rx_byte_i == hdr_second_q;
  assign status_o.len_too_big = len_too_big;
  assign status_o.len_zero    = rx_byte_i == '0;
  assign status_o.fill_done   = fill_next >= (LEN_W + 1)'(len_q);
  assign status_o.sum_match   = sum_q == rx_byte_i;
  assign status_o.frame_empty = len_q == '0;
  assign status_o.emit_last   = rd_next == (LEN_W + 1)'(len_q);
  assign status_o.out_busy    = out_valid_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign func_code_o      = out_code_q;
  assign payload_length_o = out_len_q;
  assign payload_byte_o   = out_byte_q;
  assign byte_index_o     = out_idx_q;
  assign last_o           = out_last_q;

  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd_i.out_load_data || cmd_i.out_load_empty, !out_valid_q || out_ready_i)
  `ASSERT_IMPLIES(a_store_in_range, clk_i, rst_ni, cmd_i.store_wr, fill_q < LEN_W'(MAX_PAYLOAD))
endmodule

// ===== src/serial_frame_receiver_checksum_core.sv =====
// Serial frame receiver with additive checksum: the top level.
// Depends on sfrc_pkg, sfrc_in_if, sfrc_out_if, sfrc_ctrl and sfrc_dp.
`timescale 1ns / 1ps

// The block takes one received byte, or a timeout event, per input beat. It hunts for the
// two header bytes held in the header_first and header_second registers, then reads a
// function code, a length and that many payload bytes, and finally a checksum byte that
// must equal the 8-bit wrapping sum of every byte from the first header byte through the
// last payload byte. A good frame is delivered as a run of result beats, one per payload
// byte with its index, the final one marked by last; a frame with length zero gives a
// single result with a zero payload byte. A bad checksum, a timeout or a length above
// MAX_PAYLOAD drops the frame silently and the hunt starts again; the byte that broke a
// header match is not retried as a first header byte. While receiving, one byte is taken
// per clock. After a good checksum beat the block stops taking bytes and works through the run
// one payload byte at a time, first reading the payload RAM and then loading the result
// register, which waits while the consumer stalls; the checksum beat itself waits while an
// earlier result is still unread. The last result of a run may sit in the result register
// while reception of the next frame is already under way. The payload store needs no
// clearing pass after reset: only bytes written by the current frame are ever read back.
// Header registers are written through the plain write port and should be changed only
// while the block is idle.

module serial_frame_receiver_checksum_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfrc_in_if.sink                         rx_i,
  sfrc_out_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfrc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sfrc_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns the receive phases and decides when each beat is taken.
  sfrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .timed_out_i (rx_i.timed_out),
    .in_ready_o  (rx_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the running sum, frame fields, the payload RAM and the result
  // register that decouples the result channel from the input channel.
  sfrc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_byte_i        (rx_i.rx_byte),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (res_o.valid),
    .out_ready_i      (res_o.ready),
    .func_code_o      (res_o.func_code),
    .payload_length_o (res_o.payload_length),
    .payload_byte_o   (res_o.payload_byte),
    .byte_index_o     (res_o.byte_index),
    .last_o           (res_o.last)
  );
endmodule
